// ===== rtl/hsl_pkg.sv =====
// Shared constants and types for the HSL to RGB converter.
package hsl_pkg;

	localparam int unsigned CHANNEL_BITS_DEF = 16;
	localparam int unsigned QUEUE_DEPTH_DEF  = 4;

	// Per-request classification handed from the front part to the back part.
	typedef struct packed {
		logic gray;   // zero saturation, all channels take lightness
		logic neg_r;  // ramp offset below lightness (toward p)
		logic neg_g;
		logic neg_b;
	} hsl_ctrl_t;

endpackage

// ===== rtl/hsl_front.sv =====
// Front part: request intake, hue wrap and ramp segment classification.
module hsl_front #(
	parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [CHANNEL_BITS-1:0] hue,
	input  logic [CHANNEL_BITS-1:0] saturation,
	input  logic [CHANNEL_BITS-1:0] lightness,
	output logic                    busy,
	input  logic                    q_full,
	output logic                    push,
	output logic [CHANNEL_BITS-1:0] l_out,
	output logic [CHANNEL_BITS-1:0] s_out,
	output logic [CHANNEL_BITS-2:0] a_out,
	output logic [CHANNEL_BITS-1:0] y_r,
	output logic [CHANNEL_BITS-1:0] y_g,
	output logic [CHANNEL_BITS-1:0] y_b,
	output hsl_pkg::hsl_ctrl_t      ctrl
);
	import hsl_pkg::*;

	localparam int unsigned N = CHANNEL_BITS;
	// Full scale M and its multiples, in ramp units of 1/(3M) turn
	localparam logic [N+1:0] M1   = {2'b00, {N{1'b1}}};
	localparam logic [N+1:0] M2   = {1'b0, {N{1'b1}}, 1'b0};
	localparam logic [N+1:0] M3   = M1 + M2;
	localparam logic [N+1:0] HALF = (N+2)'(1) << (N-1);
	localparam logic [N+3:0] M1W  = {2'b00, M1};
	localparam logic [N+3:0] M7W  = (M1W << 3) - M1W;

	// Returns {neg, |x|} for ramp position t in 0..3M.
	function automatic logic [N:0] ramp(input logic [N+1:0] t);
		logic [N+3:0] t4;
		logic [N+3:0] d;
		logic         neg;
		t4 = {t, 2'b00};
		if (t < HALF) begin
			// rising edge
			if (t4 < M1W) begin
				neg = 1'b1;
				d   = M1W - t4;
			end else begin
				neg = 1'b0;
				d   = t4 - M1W;
			end
		end else if ({t, 1'b0} < {1'b0, M3}) begin
			neg = 1'b0;
			d   = M1W;
		end else if (t < M2) begin
			// falling edge
			if (t4 > M7W) begin
				neg = 1'b1;
				d   = t4 - M7W;
			end else begin
				neg = 1'b0;
				d   = M7W - t4;
			end
		end else begin
			neg = 1'b1;
			d   = M1W;
		end
		return {neg, d[N-1:0]};
	endfunction

	logic [N+1:0] h3;
	logic [N+1:0] tr;
	logic [N+1:0] tb;
	logic         en1;
	logic         en2;
	logic         accept;

	logic         valid_s1;
	logic [N-1:0] l_s1;
	logic [N-1:0] s_s1;
	logic [N-2:0] a_s1;
	logic [N+1:0] tr_s1;
	logic [N+1:0] tg_s1;
	logic [N+1:0] tb_s1;

	logic         valid_s2;
	logic [N-1:0] l_s2;
	logic [N-1:0] s_s2;
	logic [N-2:0] a_s2;
	logic [N:0]   rr_s2;
	logic [N:0]   rg_s2;
	logic [N:0]   rb_s2;
	logic         gray_s2;

	assign en2    = !valid_s2 || !q_full;
	assign en1    = !valid_s1 || en2;
	assign busy   = !en1;
	assign accept = start && en1;

	// 3h, then red at +1/3 turn and blue at -1/3 turn, wrapped into 0..3M
	assign h3 = {2'b00, hue} + {1'b0, hue, 1'b0};
	assign tr = (h3 > M2) ? (h3 - M2) : (h3 + M1);
	assign tb = (h3 < M1) ? (h3 + M2) : (h3 - M1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= accept;
			if (en2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_s1  <= lightness;
			s_s1  <= saturation;
			// distance of lightness from the nearer end of the scale
			a_s1  <= lightness[N-1] ? ~lightness[N-2:0] : lightness[N-2:0];
			tr_s1 <= tr;
			tg_s1 <= h3;
			tb_s1 <= tb;
		end
		if (en2 && valid_s1) begin
			l_s2    <= l_s1;
			s_s2    <= s_s1;
			a_s2    <= a_s1;
			rr_s2   <= ramp(tr_s1);
			rg_s2   <= ramp(tg_s1);
			rb_s2   <= ramp(tb_s1);
			gray_s2 <= (s_s1 == '0);
		end
	end

	assign push       = valid_s2;
	assign l_out      = l_s2;
	assign s_out      = s_s2;
	assign a_out      = a_s2;
	assign y_r        = rr_s2[N-1:0];
	assign y_g        = rg_s2[N-1:0];
	assign y_b        = rb_s2[N-1:0];
	assign ctrl.gray  = gray_s2;
	assign ctrl.neg_r = rr_s2[N];
	assign ctrl.neg_g = rg_s2[N];
	assign ctrl.neg_b = rb_s2[N];

endmodule

// ===== rtl/hsl_queue.sv =====
// Short request queue between the front and back parts.
module hsl_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = hsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	import hsl_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

// ===== rtl/hsl_chan.sv =====
// One channel datapath: scaled product, rounding divide by M^2, offset and clamp.
module hsl_chan #(
	parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic [2*CHANNEL_BITS-2:0] ps,
	input  logic [CHANNEL_BITS-1:0]   y,
	input  logic [CHANNEL_BITS-1:0]   l,
	input  logic                      neg,
	input  logic                      gray,
	output logic [CHANNEL_BITS-1:0]   res
);
	import hsl_pkg::*;

	localparam int unsigned N = CHANNEL_BITS;
	localparam logic [2*N-1:0] MFULL = {{N{1'b0}}, {N{1'b1}}};
	localparam logic [2*N-1:0] MSQ   = MFULL * MFULL;

	logic [2*N-1:0]   pl_s2;
	logic [2*N-2:0]   ph_s2;
	logic [3*N-1:0]   w_s3;
	logic [N-1:0]     hi_s4;
	logic [2*N+1:0]   x1_s4;
	logic [N:0]       q_s5;
	logic [2*N:0]     x2_s5;
	logic [N-1:0]     mag_s6;
	logic [N-1:0]     res_s7;
	logic [N-1:0]     l_s2, l_s3, l_s4, l_s5, l_s6;
	logic [4:0]       neg_sr_q;
	logic [4:0]       gray_sr_q;

	logic [3*N-1:0]   w;
	logic [N-1:0]     hi;
	logic [2*N+1:0]   x1;
	logic [1:0]       hi2;
	logic [2*N:0]     x2;
	logic [N:0]       q3;
	logic [N:0]       sum;

	// W = 2*a*s*y + M^2; round(a*s*y / M^2) = floor(W / M^2) / 2
	assign w = {ph_s2, {(N+1){1'b0}}} + {{(N-1){1'b0}}, pl_s2, 1'b0} + {{N{1'b0}}, MSQ};

	// Fold by 2^2N = M^2 + 2^(N+1) - 1
	assign hi  = w_s3[3*N-1:2*N];
	assign x1  = {1'b0, hi, {(N+1){1'b0}}} + {2'b00, w_s3[2*N-1:0]} - {{(N+2){1'b0}}, hi};
	assign hi2 = x1_s4[2*N+1:2*N];
	assign x2  = {{(N-2){1'b0}}, hi2, {(N+1){1'b0}}} + {1'b0, x1_s4[2*N-1:0]}
		- {{(2*N-1){1'b0}}, hi2};
	assign q3  = q_s5 + {{N{1'b0}}, (x2_s5 >= {1'b0, MSQ})};
	assign sum = {1'b0, l_s6} + {1'b0, mag_s6};

	always_ff @(posedge clk) begin
		pl_s2     <= {{N{1'b0}}, ps[N-1:0]} * {{N{1'b0}}, y};
		ph_s2     <= {{N{1'b0}}, ps[2*N-2:N]} * {{(N-1){1'b0}}, y};
		w_s3      <= w;
		hi_s4     <= hi;
		x1_s4     <= x1;
		q_s5      <= {1'b0, hi_s4} + {{(N-1){1'b0}}, hi2};
		x2_s5     <= x2;
		mag_s6    <= q3[N:1];
		l_s2      <= l;
		l_s3      <= l_s2;
		l_s4      <= l_s3;
		l_s5      <= l_s4;
		l_s6      <= l_s5;
		neg_sr_q  <= {neg_sr_q[3:0], neg};
		gray_sr_q <= {gray_sr_q[3:0], gray};
		if (gray_sr_q[4]) begin
			res_s7 <= l_s6;
		end else if (neg_sr_q[4]) begin
			res_s7 <= (mag_s6 > l_s6) ? '0 : (l_s6 - mag_s6);
		end else begin
			res_s7 <= sum[N] ? {N{1'b1}} : sum[N-1:0];
		end
	end

	assign res = res_s7;

endmodule

// ===== rtl/hsl_back.sv =====
// Back part: drains the queue, shared a*s product and three channel datapaths.
module hsl_back #(
	parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	output logic                    q_pop,
	input  logic [CHANNEL_BITS-1:0] l_in,
	input  logic [CHANNEL_BITS-1:0] s_in,
	input  logic [CHANNEL_BITS-2:0] a_in,
	input  logic [CHANNEL_BITS-1:0] y_r,
	input  logic [CHANNEL_BITS-1:0] y_g,
	input  logic [CHANNEL_BITS-1:0] y_b,
	input  hsl_pkg::hsl_ctrl_t      ctrl,
	output logic                    done,
	output logic [CHANNEL_BITS-1:0] red,
	output logic [CHANNEL_BITS-1:0] green,
	output logic [CHANNEL_BITS-1:0] blue
);
	import hsl_pkg::*;

	localparam int unsigned N   = CHANNEL_BITS;
	localparam int unsigned LAT = 7;  // queue read to result register

	logic [LAT-1:0] valid_sr_q;
	logic [2*N-2:0] ps_s1;
	logic [N-1:0]   l_s1;
	logic [N-1:0]   yr_s1;
	logic [N-1:0]   yg_s1;
	logic [N-1:0]   yb_s1;
	hsl_ctrl_t      ctrl_s1;

	// Results cannot be held off, so the back part takes a request every cycle that the queue is not empty
	assign q_pop = !q_empty;
	assign done  = valid_sr_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sr_q <= '0;
		end else begin
			valid_sr_q <= {valid_sr_q[LAT-2:0], q_pop};
		end
	end

	always_ff @(posedge clk) begin
		ps_s1   <= {{N{1'b0}}, a_in} * {{(N-1){1'b0}}, s_in};
		l_s1    <= l_in;
		yr_s1   <= y_r;
		yg_s1   <= y_g;
		yb_s1   <= y_b;
		ctrl_s1 <= ctrl;
	end

	hsl_chan #(.CHANNEL_BITS(N)) u_chan_r (
		.clk  (clk),
		.ps   (ps_s1),
		.y    (yr_s1),
		.l    (l_s1),
		.neg  (ctrl_s1.neg_r),
		.gray (ctrl_s1.gray),
		.res  (red)
	);

	hsl_chan #(.CHANNEL_BITS(N)) u_chan_g (
		.clk  (clk),
		.ps   (ps_s1),
		.y    (yg_s1),
		.l    (l_s1),
		.neg  (ctrl_s1.neg_g),
		.gray (ctrl_s1.gray),
		.res  (green)
	);

	hsl_chan #(.CHANNEL_BITS(N)) u_chan_b (
		.clk  (clk),
		.ps   (ps_s1),
		.y    (yb_s1),
		.l    (l_s1),
		.neg  (ctrl_s1.neg_b),
		.gray (ctrl_s1.gray),
		.res  (blue)
	);

endmodule

// ===== rtl/hsl_to_rgb_core.sv =====
// HSL to RGB converter top level: front part, request queue, back part.
// done is raised once an accepted request has passed the front part, the queue and the back part.
// Throughput: one request per cycle; the back part drains the queue every cycle.
// busy rises only if the queue fills, which a never-stalling back part prevents.
// Reset (arst_n low) empties the pipeline and queue; no result is in flight after it.
module hsl_to_rgb_core #(
	parameter int unsigned CHANNEL_BITS = hsl_pkg::CHANNEL_BITS_DEF,
	parameter int unsigned QUEUE_DEPTH  = hsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CHANNEL_BITS-1:0] hue,
	input  logic [CHANNEL_BITS-1:0] saturation,
	input  logic [CHANNEL_BITS-1:0] lightness,
	output logic                    done,
	output logic [CHANNEL_BITS-1:0] red,
	output logic [CHANNEL_BITS-1:0] green,
	output logic [CHANNEL_BITS-1:0] blue
);
	import hsl_pkg::*;

	localparam int unsigned N  = CHANNEL_BITS;
	localparam int unsigned CB = $bits(hsl_ctrl_t);
	localparam int unsigned QW = 6 * N - 1 + CB;

	// Front part outputs
	logic          f_push;
	logic [N-1:0]  f_l;
	logic [N-1:0]  f_s;
	logic [N-2:0]  f_a;
	logic [N-1:0]  f_yr;
	logic [N-1:0]  f_yg;
	logic [N-1:0]  f_yb;
	hsl_ctrl_t     f_ctrl;

	// Queue
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	// Request accepted at this edge
	logic          accept;

	assign accept = start && !busy;

	hsl_front #(.CHANNEL_BITS(N)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.busy       (busy),
		.q_full     (q_full),
		.push       (f_push),
		.l_out      (f_l),
		.s_out      (f_s),
		.a_out      (f_a),
		.y_r        (f_yr),
		.y_g        (f_yg),
		.y_b        (f_yb),
		.ctrl       (f_ctrl)
	);

	// Queue entry: {ctrl, y_b, y_g, y_r, a, s, l}
	assign q_wdata = {f_ctrl, f_yb, f_yg, f_yr, f_a, f_s, f_l};

	hsl_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	hsl_back #(.CHANNEL_BITS(N)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.l_in    (q_rdata[N-1:0]),
		.s_in    (q_rdata[2*N-1:N]),
		.a_in    (q_rdata[3*N-2:2*N]),
		.y_r     (q_rdata[4*N-2:3*N-1]),
		.y_g     (q_rdata[5*N-2:4*N-1]),
		.y_b     (q_rdata[6*N-2:5*N-1]),
		.ctrl    (hsl_ctrl_t'(q_rdata[QW-1:6*N-1])),
		.done    (done),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

	// The back part pops every cycle, so the queue never fills
	a_queue_never_full: assert property (@(posedge clk) disable iff (!arst_n)
		!q_full)
		else $error("request queue reached full");

	// Fixed pipeline: every result traces back to an accepted request
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 10))
		else $error("result without a matching request");

	// Front part only stalls on a full queue
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_full)
		else $error("busy without queue backpressure");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the HSL to RGB converter, start/done request interface.
`timescale 1ns / 100ps

module tb;
	import hsl_pkg::*;

	localparam int unsigned CB          = CHANNEL_BITS_DEF;
	localparam int          CLK_PERIOD  = 12;
	localparam int          RESET_LEN   = 9;
	localparam int          PIPE_DRAIN  = 20;      // margin for done to follow the last accept
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          MAX_SHOWN   = 10;
	localparam int          RAND_PER_PHASE = 320;
	localparam longint      FULL        = (longint'(1) << CB) - 1;

	typedef logic [CB-1:0] chan_t;
	typedef struct packed {
		chan_t hue;
		chan_t sat;
		chan_t light;
	} hsl_t;
	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;
	typedef struct {
		hsl_t px;
		rgb_t rgb;
	} conv_t;

	// Hue positions where one of the ramps changes segment (M/6, M/3, M/2, 2M/3, 5M/6).
	localparam chan_t HUE_EDGES [5] = '{16'd10922, 16'd21845, 16'd32767, 16'd43690, 16'd54612};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	chan_t hue = '0;
	chan_t saturation = '0;
	chan_t lightness = '0;
	logic  busy;
	logic  done;
	chan_t red;
	chan_t green;
	chan_t blue;

	hsl_t  pixel_backlog[$];       // requests waiting to be driven
	conv_t rgb_due[$];             // predicted colors, oldest first
	logic  taken = 1'b0;           // request handshake completed at last rising edge
	int    idle_pct = 0;
	int    queued_count = 0;
	int    accepted_count = 0;
	int    checked_count = 0;
	int    gray_count = 0;
	int    error_count = 0;
	int    cycle_count = 0;

	hsl_to_rgb_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// round(a * s * y / M^2) with 64-bit intermediates; a <= M/2, s and y <= M
	function automatic longint amp_times(longint a, longint s, longint y);
		longint ay, g, h, hs, e, f, w, c, d, frac;
		ay = a * y;
		g = ay / FULL;
		h = ay % FULL;
		hs = h * s;
		e = hs / FULL;
		f = hs % FULL;
		w = g * s + e;
		c = w / FULL;
		d = w % FULL;
		frac = d * FULL + f;
		if (2 * frac > FULL * FULL) begin
			c++;
		end
		return c;
	endfunction

	// One channel at ramp position t (units of 1/(3M) turn).
	function automatic chan_t ramp_level(longint t, longint l, longint a, longint s);
		longint x, v;
		if (t < 0) begin
			t += 3 * FULL;
		end
		if (t > 3 * FULL) begin
			t -= 3 * FULL;       // exactly one turn stays put and lands on the floor
		end
		if (2 * t < FULL) begin
			x = 4 * t - FULL;
		end else if (2 * t < 3 * FULL) begin
			x = FULL;
		end else if (t < 2 * FULL) begin
			x = 7 * FULL - 4 * t;
		end else begin
			x = -FULL;
		end
		if (x < 0) begin
			v = l - amp_times(a, s, -x);
		end else begin
			v = l + amp_times(a, s, x);
		end
		if (v < 0) begin
			v = 0;
		end
		if (v > FULL) begin
			v = FULL;
		end
		return chan_t'(v);
	endfunction

	function automatic rgb_t hsl_to_rgb(hsl_t px);
		longint h, s, l, a;
		rgb_t c;
		h = longint'(px.hue);
		s = longint'(px.sat);
		l = longint'(px.light);
		if (s == 0) begin
			c.red = px.light;
			c.green = px.light;
			c.blue = px.light;
			return c;
		end
		// distance of lightness from the nearer end sets the swing around l
		a = (2 * l < FULL) ? l : FULL - l;
		c.red = ramp_level(3 * h + FULL, l, a, s);
		c.green = ramp_level(3 * h, l, a, s);
		c.blue = ramp_level(3 * h - FULL, l, a, s);
		return c;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_SHOWN) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	task automatic add_pixel(input chan_t h, input chan_t s, input chan_t l);
		pixel_backlog.push_back('{hue: h, sat: s, light: l});
		queued_count++;
	endtask

	// Random pixels biased toward gray, full and tiny saturation, the lightness extremes
	// and midpoint, and the hue extremes and segment edges.
	task automatic queue_random(input int n);
		chan_t h, s, l;
		int    pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				h = (pick < 4) ? '0 : '1;
			end else if (pick < 30) begin
				h = chan_t'(HUE_EDGES[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2);
			end else begin
				h = chan_t'($urandom);
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				s = '0;
			end else if (pick < 20) begin
				s = '1;
			end else if (pick < 25) begin
				s = chan_t'($urandom_range(1, 3));
			end else begin
				s = chan_t'($urandom);
			end
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				l = '0;
			end else if (pick < 16) begin
				l = '1;
			end else if (pick < 26) begin
				l = chan_t'($urandom_range(32765, 32770));
			end else begin
				l = chan_t'($urandom);
			end
			add_pixel(h, s, l);
		end
	endtask

	// Wait until every queued request is accepted and every color has come back.
	task automatic drain;
		while (accepted_count != queued_count || rgb_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Driver: a request is held until accepted, then the next one goes out
	// unless the sender idles this cycle.
	always @(negedge clk) begin
		hsl_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || taken) begin
			if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				nxt = pixel_backlog.pop_front();
				start <= 1'b1;
				hue <= nxt.hue;
				saturation <= nxt.sat;
				lightness <= nxt.light;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: compare each strobed color with the oldest prediction, then
	// record the request taken at this edge.
	always @(posedge clk) begin
		conv_t want;
		hsl_t  px;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (done) begin
				if (rgb_due.size() == 0) begin
					flag_error($sformatf("unexpected result r=%h g=%h b=%h", red, green, blue));
				end else begin
					want = rgb_due.pop_front();
					checked_count++;
					if (red !== want.rgb.red) begin
						flag_error($sformatf("hsl=%h/%h/%h red exp %h got %h", want.px.hue,
							want.px.sat, want.px.light, want.rgb.red, red));
					end
					if (green !== want.rgb.green) begin
						flag_error($sformatf("hsl=%h/%h/%h green exp %h got %h", want.px.hue,
							want.px.sat, want.px.light, want.rgb.green, green));
					end
					if (blue !== want.rgb.blue) begin
						flag_error($sformatf("hsl=%h/%h/%h blue exp %h got %h", want.px.hue,
							want.px.sat, want.px.light, want.rgb.blue, blue));
					end
				end
			end
			taken <= start && !busy;
			if (start && !busy) begin
				px = '{hue: hue, sat: saturation, light: lightness};
				rgb_due.push_back('{px: px, rgb: hsl_to_rgb(px)});
				accepted_count++;
				if (saturation == '0) begin
					gray_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				rgb_due.size());
			$display("hsl_to_rgb_core test failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_LEN) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners: gray, extremes, ramp segment edges, full-turn hue
		add_pixel(16'd0, 16'd0, 16'd0);
		add_pixel(16'hffff, 16'd0, 16'hffff);
		add_pixel(16'd12345, 16'd0, 16'd40000);
		add_pixel(16'd0, 16'hffff, 16'd32767);
		add_pixel(16'd10922, 16'hffff, 16'd32767);
		add_pixel(16'd10923, 16'hffff, 16'd32768);
		add_pixel(16'd21845, 16'hffff, 16'd32767);
		add_pixel(16'd32767, 16'hffff, 16'd32768);
		add_pixel(16'd32768, 16'hffff, 16'd32767);
		add_pixel(16'd43689, 16'hffff, 16'd32768);
		add_pixel(16'd43690, 16'hffff, 16'd32767);
		add_pixel(16'd54612, 16'hffff, 16'd32768);
		add_pixel(16'd54613, 16'hffff, 16'd32767);
		add_pixel(16'hfffe, 16'hffff, 16'd32767);
		add_pixel(16'hffff, 16'hffff, 16'd32767);
		add_pixel(16'hffff, 16'd30000, 16'd20000);
		add_pixel(16'd20000, 16'hffff, 16'd0);
		add_pixel(16'd20000, 16'hffff, 16'hffff);
		add_pixel(16'd5000, 16'd1, 16'd1);
		add_pixel(16'd50000, 16'd1, 16'hfffe);
		add_pixel(16'haaaa, 16'h5555, 16'haaaa);
		add_pixel(16'h5555, 16'haaaa, 16'h5555);
		add_pixel(16'd60000, 16'hffff, 16'd16384);
		drain();

		// random phases at different sender idle rates
		idle_pct = 0;
		queue_random(RAND_PER_PHASE);
		drain();
		idle_pct = 55;
		queue_random(RAND_PER_PHASE);
		drain();
		idle_pct = 8;
		queue_random(RAND_PER_PHASE);
		drain();
		idle_pct = 0;
		queue_random(RAND_PER_PHASE);
		drain();

		repeat (PIPE_DRAIN) @(negedge clk);
		if (rgb_due.size() != 0) begin
			flag_error($sformatf("%0d predicted colors never arrived", rgb_due.size()));
		end

		$display("Converted %0d pixels (%0d gray), checked %0d colors, %0d errors.",
			accepted_count, gray_count, checked_count, error_count);
		$display("Directed corners plus random pixels at sender idle rates 0, 55 and 8 pct.");
		if (error_count == 0) begin
			$display("hsl_to_rgb_core test passed");
		end else begin
			$display("hsl_to_rgb_core test failed");
		end
		$finish;
	end

endmodule
